// ----- design/contiguous_page_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// contiguous_page_allocator_macros.svh
// Assertion macros used by the page allocator engine. They assume a clock
// named clock and a synchronous active-high reset named reset.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cpa_pkg.sv -----
// ---------------------------------------------------------------------------
// cpa_pkg
// Types and codes of the contiguous page allocator.
// ---------------------------------------------------------------------------
package cpa_pkg;

   // page mark codes
   typedef logic [1:0] mark_type;
   localparam mark_type MARK_FREE  = 2'd0;
   localparam mark_type MARK_TAKEN = 2'd1;
   localparam mark_type MARK_LAST  = 2'd2;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_ROOM   = 2'd1;
   localparam status_type STATUS_BAD_INDEX = 2'd2;

   localparam int unsigned PAGES_RESET = 1024;

   typedef struct packed {
      logic        command;
      logic [31:0] request_bytes;
      logic [9:0]  page_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  first_page;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_MARK,
      S_FREE
   } state_type;

endpackage

// ----- design/cpa_mark_ram.sv -----
// ---------------------------------------------------------------------------
// cpa_mark_ram
// Page mark store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cpa_mark_ram
   import cpa_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  mark_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output mark_type      rd_data
);

   mark_type mem [DEPTH];
   mark_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cpa_engine.sv -----
// ---------------------------------------------------------------------------
// cpa_engine
// Sequencer of the allocator: clearing pass, first-fit scan, run marking
// and run release, all through the page mark store.
// ---------------------------------------------------------------------------
module cpa_engine
   import cpa_pkg::*;
#(
   parameter int MAX_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096,
   parameter int AW         = 10,
   parameter int CW         = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req_data,
   input  logic [CW-1:0] page_count,
   output logic          busy,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output mark_type      mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  mark_type      mem_rdata
);

   localparam logic [32:0]   PB33     = 33'(PAGE_BYTES);
   localparam logic [CW-1:0] LAST_IDX = CW'(MAX_PAGES - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] start_ff, start_in;
   logic [CW-1:0] mark_ff, mark_in;
   logic [32:0]   acc_ff, acc_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic [CW-1:0] cnt_plus;
   logic          cnt_end;
   logic [32:0]   acc_sum;
   logic          hit;
   logic          index_bad;
   logic          mark_last;
   logic [31:0]   start_wide;

   assign accept     = start && (state_ff == S_IDLE);
   assign cnt_plus   = cnt_ff + CW'(1);
   assign cnt_end    = cnt_ff >= page_count;
   assign acc_sum    = acc_ff + PB33;
   // run covers the request once its byte capacity reaches the byte count
   assign hit        = acc_sum >= {1'b0, bytes_ff};
   assign index_bad  = {22'd0, req_data.page_index} >= 32'(page_count);
   assign mark_last  = mark_ff == cnt_ff;
   assign start_wide = 32'(start_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_FREE) begin
                  state_in = index_bad ? S_IDLE : S_FREE;
               end else begin
                  state_in = (req_data.request_bytes == 32'd0) ? S_IDLE : S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            if (cnt_end) begin
               state_in = S_IDLE;
            end else if ((mem_rdata == MARK_FREE) && hit) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (mark_last) begin
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            if (cnt_end || (mem_rdata != MARK_TAKEN)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory port
   always_comb begin
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      mark_in       = mark_ff;
      acc_in        = acc_ff;
      bytes_in      = bytes_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff[AW-1:0];
      mem_wdata     = MARK_FREE;
      // read one page ahead of the one being judged
      mem_raddr     = cnt_plus[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_plus;
         end
         S_IDLE: begin
            if (accept) begin
               bytes_in = req_data.request_bytes;
               acc_in   = '0;
               start_in = '0;
               if (req_data.command == CMD_FREE) begin
                  cnt_in    = CW'(req_data.page_index);
                  mem_raddr = AW'(req_data.page_index);
                  if (index_bad) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.status     = STATUS_BAD_INDEX;
                     rsp_in.first_page = '0;
                  end
               end else begin
                  cnt_in    = '0;
                  mem_raddr = '0;
                  if (req_data.request_bytes == 32'd0) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.status     = STATUS_NO_ROOM;
                     rsp_in.first_page = '0;
                  end
               end
            end
         end
         S_ALLOC: begin
            cnt_in = cnt_plus;
            if (cnt_end) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_NO_ROOM;
               rsp_in.first_page = '0;
            end else if (mem_rdata != MARK_FREE) begin
               acc_in   = '0;
               start_in = cnt_plus;
            end else if (hit) begin
               // cnt holds the last page of the run during marking
               cnt_in  = cnt_ff;
               mark_in = start_ff;
            end else begin
               acc_in = acc_sum;
            end
         end
         S_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = mark_ff[AW-1:0];
            mem_wdata = mark_last ? MARK_LAST : MARK_TAKEN;
            mark_in   = mark_ff + CW'(1);
            if (mark_last) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_OK;
               rsp_in.first_page = start_wide[9:0];
            end
         end
         S_FREE: begin
            cnt_in = cnt_plus;
            mem_we = !cnt_end;
            if (cnt_end || (mem_rdata != MARK_TAKEN)) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = STATUS_OK;
               rsp_in.first_page = '0;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      mark_ff  <= mark_in;
      acc_ff   <= acc_in;
      bytes_ff <= bytes_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`include "contiguous_page_allocator_macros.svh"

   `CPA_ASSERT_NEXT(a_accept_answers, accept, busy || rsp_strobe, "accepted item lost")
   `CPA_ASSERT_NOW(a_rsp_idle, rsp_strobe, state_ff == S_IDLE, "result while still working")
   `CPA_ASSERT_NOW(a_scan_no_write, state_ff == S_ALLOC, !mem_we, "write during search")
   `CPA_ASSERT_NOW(a_fail_zero_page, rsp_strobe && (rsp_ff.status != STATUS_OK), rsp_ff.first_page == 10'd0, "failed result carries page")
   `CPA_ASSERT_NOW(a_clear_writes_free, state_ff == S_CLEAR, mem_we && (mem_wdata == MARK_FREE), "clearing pass skipped a page")

endmodule

// ----- design/contiguous_page_allocator.sv -----
// ---------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous page runs over a two-bit page mark store.
// ---------------------------------------------------------------------------
// After reset the block clears its page mark store, one page per cycle, and
// holds busy high meanwhile. An allocate walks the marks from page 0 one page
// a cycle through the single read port of the mark store, until a free run
// large enough is found or page_count pages are passed, then writes the run
// one page a cycle. A free walks its run one page a cycle. A zero-byte
// allocate or an out-of-range free answers in the cycle after it is accepted.
// Every item gives one result, shown for one cycle with rsp_strobe; the
// receiver cannot stall it, and a new item may start in the same cycle that
// the result is shown. The configuration port is always ready; write it only
// while busy is low.
module contiguous_page_allocator
   import cpa_pkg::*;
#(
   parameter int MAX_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int AW = $clog2(MAX_PAGES);
   localparam int CW = $clog2(MAX_PAGES + 1);

   logic [10:0]   pages_ff;
   logic [CW-1:0] page_count;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   mark_type      mem_wdata;
   logic [AW-1:0] mem_raddr;
   mark_type      mem_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= 11'(PAGES_RESET);
      end else if (csr_valid && csr_ready) begin
         pages_ff <= csr_data;
      end
   end

   // register value capped at the store depth
   assign page_count = (32'(pages_ff) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pages_ff);

   cpa_engine #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES),
      .AW         (AW),
      .CW         (CW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .page_count (page_count),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   cpa_mark_ram #(
      .DEPTH (MAX_PAGES),
      .AW    (AW)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

// ----- dv/alloc_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_check_pkg
// Page mark predictor and response scoreboard for the contiguous page
// allocator: every accepted command updates a private copy of the mark table
// and queues the status and first page that the block must answer with.
// ----------------------------------------------------------------------------
package alloc_check_pkg;
   import cpa_pkg::*;

   localparam int unsigned MAX_PAGES  = 1024;
   localparam int unsigned PAGE_BYTES = 4096;

   class alloc_scoreboard;
      mark_type    marks [MAX_PAGES];
      logic [10:0] pages_reg;
      rsp_type     pending_replies [$];
      int          errors;
      int          checked;
      int          granted;
      int          refused;
      int          bad_frees;

      function new();
         foreach (marks[i]) marks[i] = MARK_FREE;
         pages_reg = 11'(PAGES_RESET);
         errors    = 0;
         checked   = 0;
         granted   = 0;
         refused   = 0;
         bad_frees = 0;
      endfunction

      function void set_pages(logic [10:0] value);
         pages_reg = value;
      endfunction

      function int unsigned managed_pages();
         return (pages_reg > MAX_PAGES) ? MAX_PAGES : pages_reg;
      endfunction

      // predict the reply of one accepted command and queue it
      function rsp_type accept_request(req_type item);
         int unsigned     avail;
         longint unsigned bytes;
         longint unsigned need;
         int unsigned     run;
         int unsigned     first;
         int unsigned     k;
         int unsigned     m;
         bit              found;
         rsp_type         reply;
         avail = managed_pages();
         reply.status     = STATUS_OK;
         reply.first_page = '0;
         if (item.command == CMD_ALLOC) begin
            bytes = {32'd0, item.request_bytes};
            need  = (bytes + PAGE_BYTES - 1) / PAGE_BYTES;
            reply.status = STATUS_NO_ROOM;
            found = 1'b0;
            if (need != 0 && need <= avail) begin
               run   = 0;
               first = 0;
               for (k = 0; k < avail && !found; k++) begin
                  if (marks[k] != MARK_FREE) begin
                     run   = 0;
                     first = k + 1;
                  end else begin
                     run++;
                     if (run == need) begin
                        for (m = first; m < k; m++) marks[m] = MARK_TAKEN;
                        marks[k] = MARK_LAST;
                        found = 1'b1;
                        reply.status     = STATUS_OK;
                        reply.first_page = first[9:0];
                     end
                  end
               end
            end
            if (found) granted++;
            else refused++;
         end else begin
            k = 32'(item.page_index);
            if (k >= avail) begin
               reply.status = STATUS_BAD_INDEX;
               bad_frees++;
            end else begin
               // clear through the end of the run, never past the managed pages
               while (k < avail && marks[k] == MARK_TAKEN) begin
                  marks[k] = MARK_FREE;
                  k++;
               end
               if (k < avail) marks[k] = MARK_FREE;
            end
         end
         pending_replies.push_back(reply);
         return reply;
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            report($sformatf("reply status %0d page %0d with no command outstanding",
                             got.status, got.first_page));
            return;
         end
         want = pending_replies.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("reply %0d status %0d, wanted %0d",
                             checked, got.status, want.status));
         if (got.first_page !== want.first_page)
            report($sformatf("reply %0d first page %0d, wanted %0d",
                             checked, got.first_page, want.first_page));
      endtask
   endclass

endpackage

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the contiguous page allocator. A directed sequence walks the
// corner cases of allocate and free, then random bursts of run allocations
// and frees run under several page counts; every reply is checked against
// a predicted mark table.
// ----------------------------------------------------------------------------
module tb;
   import cpa_pkg::*;
   import alloc_check_pkg::*;

   localparam int LIMIT = 2500000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        start      = 1'b0;
   req_type     req_data   = '0;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_data   = '0;

   alloc_scoreboard sb = new();
   int              cycles = 0;
   int              sent = 0;
   int              settings_used = 0;
   int unsigned     live_starts [$];

   contiguous_page_allocator #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_data);
   end

   function automatic req_type alloc_req(logic [31:0] bytes);
      req_type item;
      item.command       = CMD_ALLOC;
      item.request_bytes = bytes;
      item.page_index    = 10'($urandom_range(1023));
      return item;
   endfunction

   function automatic req_type free_req(int unsigned index);
      req_type item;
      item.command       = CMD_FREE;
      item.request_bytes = $urandom();
      item.page_index    = index[9:0];
      return item;
   endfunction

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic issue(req_type item);
      rsp_type predicted;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predicted = sb.accept_request(item);
      sent++;
      if (item.command == CMD_ALLOC && predicted.status == STATUS_OK)
         live_starts.push_back(32'(predicted.first_page));
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_pages(logic [10:0] value);
      drain();
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_pages(value);
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type next_item(int unsigned avail);
      int unsigned roll;
      int unsigned span;
      int unsigned npages;
      int unsigned pick;
      roll = $urandom_range(99);
      span = (avail == 0) ? 1 : ((avail < 6) ? avail : 6);
      if (roll < 45) begin
         npages = (roll < 4 && avail > 0) ? $urandom_range(avail, 1) : $urandom_range(span, 1);
         return alloc_req((npages - 1) * PAGE_BYTES + $urandom_range(PAGE_BYTES, 1));
      end else if (roll < 75) begin
         if (live_starts.size() != 0) begin
            pick = $urandom_range(live_starts.size() - 1);
            npages = live_starts[pick];
            live_starts.delete(pick);
            return free_req(npages);
         end
         return free_req($urandom_range((avail == 0) ? 0 : avail - 1));
      end else if (roll < 85) begin
         return alloc_req(($urandom_range(3) == 0) ? 32'd0 : $urandom());
      end
      return free_req($urandom_range(1023));
   endfunction

   task automatic run_phase(logic [10:0] pages, int count, bit hold_midway);
      int unsigned avail;
      int          burst_left;
      int          gap;
      write_pages(pages);
      avail = (pages > MAX_PAGES) ? MAX_PAGES : pages;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(10, 1);
         end
         issue(next_item(avail));
         burst_left--;
         // hold off until every outstanding reply is in
         if (hold_midway && i == count / 2) drain();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      write_pages(11'd1024);
      issue(alloc_req(32'd0));
      issue(alloc_req(32'd1));
      issue(alloc_req(PAGE_BYTES));
      issue(alloc_req(PAGE_BYTES + 1));
      issue(alloc_req(32'hFFFF_FFFF));
      issue(alloc_req(MAX_PAGES * PAGE_BYTES));
      issue(free_req(1023));                 // page already free
      issue(free_req(3));                    // last page of a run
      issue(free_req(0));
      issue(free_req(1));
      issue(alloc_req(PAGE_BYTES));

      write_pages(11'd4);
      issue(free_req(4));
      issue(free_req(1023));
      issue(alloc_req(4 * PAGE_BYTES));

      write_pages(11'd0);                    // no pages managed
      issue(alloc_req(32'd1));
      issue(free_req(0));

      write_pages(11'd2047);                 // capped to the table size
      issue(free_req(2));
      issue(free_req(0));
      issue(alloc_req(MAX_PAGES * PAGE_BYTES));

      write_pages(11'd8);                    // free stops at the last managed page
      issue(free_req(0));

      write_pages(11'd1024);
      issue(alloc_req(9 * PAGE_BYTES));
      issue(free_req(8));

      live_starts.delete();
      run_phase(11'd16, 60, 1'b1);
      run_phase(11'd64, 50, 1'b0);
      run_phase(11'd1, 15, 1'b0);
      run_phase(11'd1024, 35, 1'b0);
      run_phase(11'd200, 40, 1'b1);
      run_phase(11'd2047, 25, 1'b0);
      run_phase(11'd0, 10, 1'b0);
      run_phase(11'd37, 35, 1'b0);

      drain();
      repeat (2 * MAX_PAGES + 16) @(negedge clock);
      if (sb.pending_replies.size() != 0)
         sb.report($sformatf("%0d replies never arrived", sb.pending_replies.size()));

      $display("tb: %0d commands over %0d page-count settings, %0d replies checked",
               sent, settings_used, sb.checked);
      $display("tb: %0d runs granted, %0d allocations refused, %0d frees out of range",
               sb.granted, sb.refused, sb.bad_frees);
      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
